// ===== rtl/core/tmct_pkg.sv =====
// Shared types and constants for the torus mesh cell tessellator.
`timescale 1ns / 1ps
package tmct_pkg;

  localparam int unsigned CoordW   = 19;
  localparam int unsigned RadiusW  = 16;
  localparam int unsigned SegW     = 9;
  localparam int unsigned StepW    = 16;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SineW    = 17;

  localparam logic [CfgIdxW-1:0] RegMajor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSegs  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStep  = 3'd3;

  localparam logic [SegW-1:0] MinSegs = 9'd3;

  typedef struct packed {
    logic valid;
    logic bad;
    logic last;
  } side_t;

endpackage

// ===== rtl/core/tmct_sine.sv =====
// Five-stage pipelined polynomial sine on a 16-bit turn angle, Q1.15 result.
`timescale 1ns / 1ps
module tmct_sine
  import tmct_pkg::*;
(
  input  logic                    clk_i,
  input  logic [15:0]             turn_i,
  output logic signed [SineW-1:0] sin_o
);

  logic [15:0] x_a_q, x_b_q, x_c_q, x_d_q;
  logic [15:0] x2_b_q, x2_c_q;
  logic [14:0] t1_c_q;
  logic [15:0] t2_d_q;
  logic        neg_a_q, neg_b_q, neg_c_q, neg_d_q;
  logic signed [SineW-1:0] sin_q;

  logic [14:0] arg;
  logic [31:0] sq, m1, m2, m3;
  logic [16:0] mag;

  always_comb begin
    arg = turn_i[14] ? (15'd16384 - {1'b0, turn_i[13:0]}) : {1'b0, turn_i[13:0]};
    sq  = 32'(x_a_q) * 32'(x_a_q);
    m1  = 32'd2320 * 32'(x2_b_q);
    m2  = 32'(t1_c_q) * 32'(x2_c_q);
    m3  = 32'(t2_d_q) * 32'(x_d_q);
    mag = (m3[31:15] > 17'd32768) ? 17'd32768 : m3[31:15];
  end

  always_ff @(posedge clk_i) begin
    x_a_q   <= {arg, 1'b0};
    neg_a_q <= turn_i[15];
    x2_b_q  <= sq[30:15];
    x_b_q   <= x_a_q;
    neg_b_q <= neg_a_q;
    t1_c_q  <= 15'(32'd21024 - (m1 >> 15));
    x2_c_q  <= x2_b_q;
    x_c_q   <= x_b_q;
    neg_c_q <= neg_b_q;
    t2_d_q  <= 16'(32'd51472 - (m2 >> 15));
    x_d_q   <= x_c_q;
    neg_d_q <= neg_c_q;
    sin_q   <= neg_d_q ? -$signed(mag) : $signed(mag);
  end

  assign sin_o = sin_q;

endmodule

// ===== rtl/core/tmct_vertex.sv =====
// Vertex pipeline: sines of both angles, radius products, rounding and saturation.
`timescale 1ns / 1ps
module tmct_vertex
  import tmct_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ANGLE_BITS-1:0]   theta_i,
  input  logic [ANGLE_BITS-1:0]   phi_i,
  input  side_t                   side_i,
  input  logic [RadiusW-1:0]      major_i,
  input  logic [RadiusW-1:0]      minor_i,
  output logic signed [CoordW-1:0] x_o,
  output logic signed [CoordW-1:0] y_o,
  output logic signed [CoordW-1:0] z_o,
  output side_t                   side_o
);

  localparam int unsigned DelayN = 6;
  localparam int unsigned WideW  = 53;

  logic [ANGLE_BITS-1:0] theta_q, phi_q;
  side_t sd_q [DelayN];
  side_t side_f_q, side_g_q, side_h_q;
  logic [15:0] t_turn, p_turn;
  logic signed [SineW-1:0] sin_t, cos_t, sin_p, cos_p;
  logic signed [35:0] w_f_q;
  logic signed [33:0] z_f_q, z_g_q;
  logic signed [SineW-1:0] sp_f_q, cp_f_q;
  logic signed [WideW-1:0] px_g_q, py_g_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q;

  generate
    if (ANGLE_BITS >= 16) begin : g_down
      assign t_turn = theta_q[ANGLE_BITS-1 -: 16];
      assign p_turn = phi_q[ANGLE_BITS-1 -: 16];
    end else begin : g_up
      assign t_turn = {theta_q, {(16-ANGLE_BITS){1'b0}}};
      assign p_turn = {phi_q, {(16-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  tmct_sine u_sin_t (.clk_i, .turn_i(t_turn), .sin_o(sin_t));
  tmct_sine u_cos_t (.clk_i, .turn_i(t_turn + 16'd16384), .sin_o(cos_t));
  tmct_sine u_sin_p (.clk_i, .turn_i(p_turn), .sin_o(sin_p));
  tmct_sine u_cos_p (.clk_i, .turn_i(p_turn + 16'd16384), .sin_o(cos_p));

  function automatic logic signed [CoordW-1:0] rnd_sat(input logic signed [WideW-1:0] v,
                                                       input logic sel15);
    logic             neg;
    logic [WideW-1:0] mag, m;
    neg = v[WideW-1];
    mag = neg ? WideW'(-v) : WideW'(v);
    m   = sel15 ? ((mag + (WideW'(1) << 14)) >> 15) : ((mag + (WideW'(1) << 29)) >> 30);
    if (!neg && m > WideW'(262143)) begin
      return CoordW'(262143);
    end else if (neg && m > WideW'(262144)) begin
      return CoordW'(-262144);
    end else begin
      return neg ? CoordW'(-$signed(m)) : CoordW'(m);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DelayN; k++) sd_q[k] <= '0;
      side_f_q <= '0;
      side_g_q <= '0;
      side_h_q <= '0;
    end else begin
      sd_q[0] <= side_i;
      for (int k = 1; k < DelayN; k++) sd_q[k] <= sd_q[k-1];
      side_f_q <= sd_q[DelayN-1];
      side_g_q <= side_f_q;
      side_h_q <= side_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    theta_q <= theta_i;
    phi_q   <= phi_i;
    w_f_q   <= $signed({5'd0, major_i, 15'd0})
             + 36'($signed({1'b0, minor_i}) * cos_t);
    z_f_q   <= $signed({1'b0, minor_i}) * sin_t;
    sp_f_q  <= sin_p;
    cp_f_q  <= cos_p;
    px_g_q  <= w_f_q * cp_f_q;
    py_g_q  <= w_f_q * sp_f_q;
    z_g_q   <= z_f_q;
    if (side_g_q.bad) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else begin
      x_q <= rnd_sat(px_g_q, 1'b0);
      y_q <= rnd_sat(py_g_q, 1'b0);
      z_q <= rnd_sat(WideW'(z_g_q), 1'b1);
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_h_q;

endmodule

// ===== rtl/core/torus_mesh_cell_tessellator_core.sv =====
// Each cell gives six vertices, one vertex per cycle; a cell with bad parameters
// gives one result only. A new start is taken while the last vertex of a cell issues.
// The vertex pipeline takes a new vertex every cycle; the receiver cannot stall.
// Reset restores the register defaults and empties the pipeline.
`timescale 1ns / 1ps
module torus_mesh_cell_tessellator_core
  import tmct_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [IndexW-1:0]        ring_index_i,
  input  logic [IndexW-1:0]        tube_index_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  output logic                     vert_valid_o,
  output logic signed [CoordW-1:0] vert_x_o,
  output logic signed [CoordW-1:0] vert_y_o,
  output logic signed [CoordW-1:0] vert_z_o,
  output logic                     params_bad_o,
  output logic                     last_vertex_o
);

  localparam int unsigned ProdW = IndexW + StepW;

  logic [RadiusW-1:0] major_q, minor_q;
  logic [SegW-1:0]    segs_q;
  logic [StepW-1:0]   step_q;

  logic [ANGLE_BITS-1:0] phi_q, theta_q, phi2, theta2, step_a;
  logic [ANGLE_BITS-1:0] v_theta, v_phi;
  logic [2:0] cnt_q;
  logic       active_q, bad_q, accept;
  logic [ProdW-1:0] phi_p, theta_p;
  side_t v_side, out_side;

  assign busy   = active_q && (cnt_q != 3'd5);
  assign accept = start && !busy;
  assign step_a = ANGLE_BITS'(step_q);
  assign phi2   = phi_q + step_a;
  assign theta2 = theta_q + step_a;
  assign phi_p   = ProdW'(ring_index_i) * ProdW'(step_q);
  assign theta_p = ProdW'(tube_index_i) * ProdW'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= 16'd512;
      minor_q <= 16'd256;
      segs_q  <= 9'd16;
      step_q  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMajor: major_q <= cfg_wdata_i;
        RegMinor: minor_q <= cfg_wdata_i;
        RegSegs:  segs_q  <= cfg_wdata_i[SegW-1:0];
        RegStep:  step_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      bad_q    <= 1'b0;
    end else if (accept) begin
      active_q <= 1'b1;
      bad_q    <= (major_q <= minor_q) || (segs_q <= MinSegs);
      cnt_q    <= ((major_q <= minor_q) || (segs_q <= MinSegs)) ? 3'd5 : 3'd0;
    end else if (active_q) begin
      // drop out after the sixth vertex
      if (cnt_q == 3'd5) active_q <= 1'b0;
      else cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phi_q   <= phi_p[ANGLE_BITS-1:0];
      theta_q <= theta_p[ANGLE_BITS-1:0];
    end
  end

  // vertex order A B C A C D
  always_comb begin
    v_theta = theta_q;
    v_phi   = phi_q;
    case (cnt_q)
      3'd1: begin v_theta = theta2; v_phi = phi_q; end
      3'd2: begin v_theta = theta2; v_phi = phi2;  end
      3'd4: begin v_theta = theta2; v_phi = phi2;  end
      3'd5: begin v_theta = theta_q; v_phi = phi2; end
      default: begin v_theta = theta_q; v_phi = phi_q; end
    endcase
    v_side.valid = active_q;
    v_side.bad   = bad_q;
    v_side.last  = (cnt_q == 3'd5);
  end

  tmct_vertex #(.ANGLE_BITS(ANGLE_BITS)) u_vertex (
    .clk_i,
    .rst_ni,
    .theta_i (v_theta),
    .phi_i   (v_phi),
    .side_i  (v_side),
    .major_i (major_q),
    .minor_i (minor_q),
    .x_o     (vert_x_o),
    .y_o     (vert_y_o),
    .z_o     (vert_z_o),
    .side_o  (out_side)
  );

  assign vert_valid_o  = out_side.valid;
  assign params_bad_o  = out_side.bad;
  assign last_vertex_o = out_side.last;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the torus mesh cell tessellator core.
`timescale 1ns / 1ps
module testbench;
  import tmct_pkg::*;

  localparam int unsigned ABITS = 16;
  localparam int unsigned WATCH_LIMIT = 2000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic bad;
    logic last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IndexW-1:0] ring_index_i = '0;
  logic [IndexW-1:0] tube_index_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic vert_valid_o;
  logic signed [CoordW-1:0] vert_x_o, vert_y_o, vert_z_o;
  logic params_bad_o, last_vertex_o;

  torus_mesh_cell_tessellator_core #(.ANGLE_BITS(ABITS)) DUT (.*);

  // shadow of the block's registers
  logic [RadiusW-1:0] major_q = 16'd512;
  logic [RadiusW-1:0] minor_q = 16'd256;
  logic [SegW-1:0]    segs_q  = 9'd16;
  logic [StepW-1:0]   step_q  = 16'd4096;

  vertex_t pending_verts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint quarter_sine(int unsigned arg);
    longint unsigned x, x2, t;
    x = arg << 1;
    x2 = (x * x) >> 15;
    t = (64'd2320 * x2) >> 15;
    t = 64'd21024 - t;
    t = (t * x2) >> 15;
    t = 64'd51472 - t;
    t = (t * x) >> 15;
    if (t > 32768) t = 32768;
    return longint'(t);
  endfunction

  function automatic longint sine_turn(logic [15:0] u);
    logic [1:0] q;
    logic [13:0] f;
    int unsigned arg;
    longint s;
    q = u[15:14];
    f = u[13:0];
    arg = q[0] ? (16384 - f) : f;
    s = quarter_sine(arg);
    return q[1] ? -s : s;
  endfunction

  function automatic longint cosine_turn(logic [15:0] u);
    return sine_turn(u + 16'd16384);
  endfunction

  function automatic logic [15:0] turn16(longint unsigned a);
    a &= (64'd1 << ABITS) - 1;
    if (ABITS > 16) return 16'(a >> (ABITS - 16));
    return 16'(a << (16 - ABITS));
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint unsigned half;
    half = 64'd1 << (s - 1);
    if (v < 0) return -longint'((unsigned'(-v) + half) >> s);
    return longint'((unsigned'(v) + half) >> s);
  endfunction

  function automatic logic [CoordW-1:0] clamp_coord(longint v);
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v[CoordW-1:0];
  endfunction

  function automatic vertex_t torus_point(longint unsigned tha, longint unsigned pha,
                                          bit last);
    vertex_t v;
    logic [15:0] t, p;
    longint r, w;
    t = turn16(tha);
    p = turn16(pha);
    r = minor_q;
    w = longint'(major_q) * 32768 + r * cosine_turn(t);
    v.x = clamp_coord(round_shift(w * cosine_turn(p), 30));
    v.y = clamp_coord(round_shift(w * sine_turn(p), 30));
    v.z = clamp_coord(round_shift(r * sine_turn(t), 15));
    v.bad = 1'b0;
    v.last = last;
    return v;
  endfunction

  task automatic predict_cell(logic [7:0] ri, logic [7:0] ti);
    longint unsigned m, ph, th, ph2, th2;
    vertex_t b;
    if (major_q <= minor_q || segs_q <= MinSegs) begin
      b = '0;
      b.bad = 1'b1;
      b.last = 1'b1;
      pending_verts.push_back(b);
      return;
    end
    m = (64'd1 << ABITS) - 1;
    ph = (ri * step_q) & m;
    th = (ti * step_q) & m;
    ph2 = (ph + step_q) & m;
    th2 = (th + step_q) & m;
    pending_verts.push_back(torus_point(th, ph, 0));
    pending_verts.push_back(torus_point(th2, ph, 0));
    pending_verts.push_back(torus_point(th2, ph2, 0));
    pending_verts.push_back(torus_point(th, ph, 0));
    pending_verts.push_back(torus_point(th2, ph2, 0));
    pending_verts.push_back(torus_point(th, ph2, 1));
  endtask

  // check each vertex against the oldest expectation
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && vert_valid_o) begin
      if (pending_verts.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d z=%0d", $time,
                 vert_x_o, vert_y_o, vert_z_o);
        errors++;
      end else begin
        e = pending_verts.pop_front();
        if (vert_x_o !== e.x) begin
          $display("%0t: x exp %0d got %0d", $time, e.x, vert_x_o); errors++;
        end
        if (vert_y_o !== e.y) begin
          $display("%0t: y exp %0d got %0d", $time, e.y, vert_y_o); errors++;
        end
        if (vert_z_o !== e.z) begin
          $display("%0t: z exp %0d got %0d", $time, e.z, vert_z_o); errors++;
        end
        if (params_bad_o !== e.bad) begin
          $display("%0t: bad exp %0b got %0b", $time, e.bad, params_bad_o); errors++;
        end
        if (last_vertex_o !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, last_vertex_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles out of reset with no accepted item, vertex or register write
  always @(posedge clk_i) begin
    if ((start && !busy) || vert_valid_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_cell(logic [7:0] ri, logic [7:0] ti);
    int gap;
    cfg_we_i <= 1'b0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    ring_index_i <= ri;
    tube_index_i <= ti;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_cell(ri, ti);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegMajor: major_q = val;
      RegMinor: minor_q = val;
      RegSegs:  segs_q = val[SegW-1:0];
      RegStep:  step_q = val;
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [15:0] rm, logic [15:0] rn, logic [15:0] n,
                           logic [15:0] d);
    drain();
    write_reg(RegMajor, rm);
    write_reg(RegMinor, rn);
    write_reg(RegSegs, n);
    write_reg(RegStep, d);
  endtask

  task automatic test_reset_defaults;
    send_cell(8'd0, 8'd0);
    send_cell(8'd15, 8'd15);
    send_cell(8'd255, 8'd255);
    send_cell(8'd3, 8'd12);
  endtask

  task automatic test_extremes;
    set_shape(16'hFFFF, 16'hFFFE, 16'd256, 16'hFFFF);
    send_cell(8'd0, 8'd255);
    send_cell(8'd255, 8'd0);
    set_shape(16'd1, 16'd0, 16'd4, 16'd0);
    send_cell(8'd77, 8'd200);
    set_shape(16'hFFFF, 16'd0, 16'h1FF, 16'd16384);
    send_cell(8'd1, 8'd2);
    send_cell(8'd255, 8'd255);
    drain();
    write_reg(3'd7, 16'hFFFF); // unmapped index, ignored
    write_reg(3'd5, 16'h0);
    send_cell(8'd10, 8'd20);
  endtask

  task automatic test_bad_params;
    set_shape(16'd256, 16'd256, 16'd16, 16'd4096); // R equal to r
    send_cell(8'd1, 8'd1);
    set_shape(16'd100, 16'd300, 16'd16, 16'd4096); // R below r
    send_cell(8'hAA, 8'h55);
    set_shape(16'd512, 16'd256, 16'd3, 16'd4096);  // too few segments
    send_cell(8'h55, 8'hAA);
    set_shape(16'd512, 16'd256, 16'd0, 16'd4096);
    send_cell(8'd0, 8'd0);
    set_shape(16'd512, 16'd256, 16'd4, 16'd16384);
    send_cell(8'd3, 8'd3);
  endtask

  task automatic test_random;
    logic [15:0] rm, rn, n;
    for (int ph = 0; ph < 11; ph++) begin
      rn = $urandom_range(0, 65535);
      rm = $urandom_range(0, 65535);
      if ($urandom_range(0, 4) != 0 && rm <= rn) begin
        rm = rn | 16'h8000;
        rn = rn & 16'h7FFF;
      end
      n = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3))
                                      : 16'($urandom_range(4, 511));
      set_shape(rm, rn, n, (n > 16'd3 && $urandom_range(0, 1) != 0)
                           ? 16'(65536 / n) : 16'($urandom_range(0, 65535)));
      if (ph >= 9) quiet = 1;
      for (int k = 0; k < 20; k++)
        send_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_bad_params();
    test_random();
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
